// ===== hdl/max_flow_isap_gap_core_macros.svh =====
// assertion macros for the max flow core checker
// used by the checker file, no other dependencies
`ifndef MAX_FLOW_ISAP_GAP_CORE_MACROS_SVH
`define MAX_FLOW_ISAP_GAP_CORE_MACROS_SVH

// clocked assertion, disabled while reset is low
`define MFISAP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define MFISAP_ASSERT_NR(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mfisap_pkg.sv =====
// shared types and constants for the max flow core
// no dependencies
package mfisap_pkg;

    localparam int DEF_MAX_NODES     = 1024;
    localparam int DEF_MAX_ARCS      = 4096;
    localparam int DEF_CAPACITY_BITS = 31;

    localparam int PORT_NODE_W = 10;
    localparam int PORT_CAP_W  = 31;
    localparam int PORT_CNT_W  = 11;
    localparam int OUT_FLOW_W  = 42;
    localparam int FLOW_W      = 31;
    localparam logic [FLOW_W-1:0] PASS_LIMIT = FLOW_W'(1) << 30;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_SOURCE = 2'd0;
    localparam logic [1:0] REG_SINK   = 2'd1;
    localparam logic [1:0] REG_NCOUNT = 2'd2;

    localparam logic [PORT_NODE_W-1:0] SOURCE_RST = PORT_NODE_W'(0);
    localparam logic [PORT_NODE_W-1:0] SINK_RST   = PORT_NODE_W'(1);
    localparam logic [PORT_CNT_W-1:0]  NCOUNT_RST = PORT_CNT_W'(1024);

    localparam logic ACT_ADD     = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [PORT_NODE_W-1:0] edge_tail;
        logic [PORT_NODE_W-1:0] edge_head;
        logic [PORT_CAP_W-1:0]  edge_capacity;
    } in_word_t;

    typedef struct packed {
        logic [OUT_FLOW_W-1:0] flow_total;
        logic                  table_overflow;
    } out_word_t;

endpackage

// ===== hdl/mfisap_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module mfisap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/max_flow_isap_gap_core.sv =====
// max flow core: arc loading and isap max flow with gap heuristic
// depends on mfisap_pkg and mfisap_ram
//
//  channel | ports           | moves
//  --------+-----------------+------------------------------------------
//  input   | s_valid/s_ready | in_word_t: add arc or compute request
//  result  | m_valid/m_ready | out_word_t: flow total and overflow flag
//  config  | apb psel..pready| source, sink, node count at 0x0, 0x4, 0x8
//
// an add word runs the first_arc read-modify-write of both ends in ADD1, ADD2 and ADD3
// a compute word runs label init and seed, a bfs from the sink over each queued node and
// its arcs, then per pass a copy of first_arc into cur_arc and a start, an arc scan with
// push, relabel and pop, and last a clear of first_arc
// reset starts the same clear; s_ready stays low during it
// a finished result waits in the output register while the next word is taken
module max_flow_isap_gap_core
    #(
    parameter int MAX_NODES     = mfisap_pkg::DEF_MAX_NODES,
    parameter int MAX_ARCS      = mfisap_pkg::DEF_MAX_ARCS,
    parameter int CAPACITY_BITS = mfisap_pkg::DEF_CAPACITY_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mfisap_pkg::in_word_t        s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mfisap_pkg::out_word_t       m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mfisap_pkg::PADDR_W-1:0] paddr,
    input  logic [mfisap_pkg::PDATA_W-1:0] pwdata,
    output logic [mfisap_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    import mfisap_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int AW  = $clog2(MAX_ARCS);
    localparam int LW  = NW + 2;
    localparam int CW  = NW + 1;
    localparam int GS  = MAX_NODES + 2;
    localparam int GW  = $clog2(GS);
    localparam int SD  = MAX_NODES + 1;
    localparam int SDW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int FW  = FLOW_W;
    localparam int FRW = NW + 2 * FW;
    localparam int RW  = CAPACITY_BITS;
    localparam int XW  = (RW > FW) ? RW : FW;
    localparam int IW  = (RW > PORT_CAP_W) ? RW : PORT_CAP_W;
    localparam int KW  = $clog2(GS + 1);
    localparam logic [IW-1:0] CAP_MAX = IW'({RW{1'b1}});

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_ADD1, ST_ADD2, ST_ADD3,
        ST_INIT, ST_SEED, ST_BPOP, ST_BP, ST_BA0, ST_BARC, ST_BH, ST_BR, ST_BG,
        ST_PCHK, ST_COPY, ST_PSTART, ST_PNODE, ST_PCA, ST_PSCAN, ST_PH, ST_PL,
        ST_R1, ST_R2, ST_R3, ST_POP, ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_DONE
    } state_t;

    function automatic logic [GW-1:0] gap_slot(input logic [LW-1:0] lab);
        gap_slot = (32'(lab) >= GS) ? GW'(GS - 1) : GW'(lab);
    endfunction

    state_t state_reg;
    logic [KW-1:0]          cnt_reg;
    logic [PORT_NODE_W-1:0] src_reg, snk_reg;
    logic [PORT_CNT_W-1:0]  ncount_reg;
    logic [CW-1:0]          n_reg;
    logic [AW-1:0]          arc_total_reg, a_reg, cur_a_reg;
    logic                   ovf_reg, gz_reg;
    logic [NW-1:0]          tail_reg, head_reg, p_reg, h_reg, top_node_reg;
    logic [NW-1:0]          s_idx_reg, t_idx_reg;
    logic [RW-1:0]          cap_reg;
    logic [OUT_FLOW_W-1:0]  sum_reg;
    logic [CW-1:0]          front_reg, rear_reg;
    logic [LW-1:0]          dp_reg, ls_reg;
    logic [FW-1:0]          top_limit_reg, top_got_reg, ret_reg;
    logic [SPW-1:0]         sp_reg;
    logic [GW-1:0]          slot_reg;
    logic                   m_valid_reg;
    out_word_t              m_data_reg;

    logic hd_we, hd_re, ln_we, ln_re, rs_we, rs_re;
    logic [AW-1:0] hd_waddr, hd_raddr, ln_waddr, ln_raddr, rs_waddr, rs_raddr;
    logic [NW-1:0] hd_wdata, hd_rdata;
    logic [AW-1:0] ln_wdata, ln_rdata;
    logic [RW-1:0] rs_wdata, rs_rdata;
    logic fa_we, fa_re, ca_we, ca_re;
    logic [NW-1:0] fa_waddr, fa_raddr, ca_waddr, ca_raddr;
    logic [AW-1:0] fa_wdata, fa_rdata, ca_wdata, ca_rdata;
    logic lb_we, lb_re, rc_we, rc_re, rc_wdata, rc_rdata;
    logic [NW-1:0] lb_waddr, lb_raddr, rc_waddr, rc_raddr;
    logic [LW-1:0] lb_wdata, lb_rdata;
    logic gp_we, gp_re;
    logic [GW-1:0] gp_waddr, gp_raddr;
    logic [CW-1:0] gp_wdata, gp_rdata;
    logic qu_we, qu_re;
    logic [NW-1:0] qu_waddr, qu_raddr, qu_wdata, qu_rdata;
    logic st_we, st_re;
    logic [SDW-1:0] st_waddr, st_raddr;
    logic [FRW-1:0] st_wdata, st_rdata;

    logic [KW-1:0]  cnt_m1;
    logic [SPW-1:0] sp_m1, sp_m2;
    logic [NW-1:0]  in_tail, in_head, fr_node;
    logic [IW-1:0]  in_cap;
    logic [RW-1:0]  cap_sat;
    logic [FW-1:0]  room, child_limit, got_sum, fr_limit, fr_got;
    logic [CW-1:0]  gap_dec;
    logic           gap_zero, admissible;
    logic [LW-1:0]  new_lab;
    logic           in_ok, run_ok, cfg_wr;

    assign cnt_m1  = cnt_reg - KW'(1);
    assign sp_m1   = sp_reg - SPW'(1);
    assign sp_m2   = sp_reg - SPW'(2);
    assign in_tail = NW'(s_data.edge_tail);
    assign in_head = NW'(s_data.edge_head);
    assign in_cap  = IW'(s_data.edge_capacity);
    assign cap_sat = (in_cap > CAP_MAX) ? RW'(CAP_MAX) : RW'(in_cap);
    assign in_ok   = (32'(s_data.edge_tail) < MAX_NODES) && (32'(s_data.edge_head) < MAX_NODES);
    assign run_ok  = (32'(src_reg) < MAX_NODES) && (32'(snk_reg) < MAX_NODES)
                     && (src_reg != snk_reg);
    assign room        = top_limit_reg - top_got_reg;
    assign child_limit = (XW'(room) < XW'(rs_rdata)) ? room : FW'(rs_rdata);
    assign got_sum     = top_got_reg + ret_reg;
    assign gap_dec     = (gp_rdata != '0) ? gp_rdata - CW'(1) : '0;
    assign gap_zero    = (gap_dec == '0);
    assign new_lab     = (gz_reg && p_reg == s_idx_reg) ? LW'(n_reg) + LW'(1)
                                                        : dp_reg + LW'(1);
    assign admissible  = ({1'b0, dp_reg} == {1'b0, lb_rdata} + (LW + 1)'(1))
                         && (rs_rdata != '0) && (32'(sp_reg) < SD);
    assign {fr_node, fr_limit, fr_got} = st_rdata;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        hd_we = 1'b0; hd_waddr = a_reg; hd_wdata = head_reg;
        ln_we = 1'b0; ln_waddr = a_reg; ln_wdata = fa_rdata;
        rs_we = 1'b0; rs_waddr = a_reg; rs_wdata = cap_reg;
        hd_re = 1'b0; ln_re = 1'b0; rs_re = 1'b0;
        hd_raddr = cur_a_reg; ln_raddr = cur_a_reg; rs_raddr = cur_a_reg;
        fa_we = 1'b0; fa_waddr = tail_reg; fa_wdata = a_reg;
        fa_re = 1'b0; fa_raddr = in_tail;
        ca_we = 1'b0; ca_waddr = p_reg; ca_wdata = ln_rdata;
        ca_re = 1'b0; ca_raddr = top_node_reg;
        lb_we = 1'b0; lb_waddr = h_reg; lb_wdata = dp_reg + LW'(1);
        lb_re = 1'b0; lb_raddr = p_reg;
        rc_we = 1'b0; rc_waddr = h_reg; rc_wdata = 1'b1;
        rc_re = 1'b0; rc_raddr = hd_rdata;
        gp_we = 1'b0; gp_waddr = slot_reg; gp_wdata = gp_rdata + CW'(1);
        gp_re = 1'b0; gp_raddr = slot_reg;
        qu_we = 1'b0; qu_waddr = NW'(rear_reg); qu_wdata = h_reg;
        qu_re = 1'b0; qu_raddr = NW'(front_reg);
        st_we = 1'b0; st_waddr = sp_m1[SDW-1:0];
        st_wdata = {top_node_reg, top_limit_reg, top_got_reg};
        st_re = 1'b0; st_raddr = sp_m2[SDW-1:0];
        case (state_reg)
            ST_CLEAR: begin
                fa_we = 1'b1; fa_waddr = cnt_reg[NW-1:0]; fa_wdata = '0;
            end
            ST_IDLE: begin
                fa_re = 1'b1;
            end
            ST_ADD1: begin
                hd_we = 1'b1; ln_we = 1'b1; rs_we = 1'b1; fa_we = 1'b1;
            end
            ST_ADD2: begin
                fa_re = 1'b1; fa_raddr = head_reg;
            end
            ST_ADD3: begin
                hd_we = 1'b1; hd_waddr = a_reg + AW'(1); hd_wdata = tail_reg;
                ln_we = 1'b1; ln_waddr = a_reg + AW'(1);
                rs_we = 1'b1; rs_waddr = a_reg + AW'(1); rs_wdata = '0;
                fa_we = 1'b1; fa_waddr = head_reg; fa_wdata = a_reg + AW'(1);
            end
            ST_INIT: begin
                gp_we = 1'b1; gp_waddr = cnt_reg[GW-1:0]; gp_wdata = '0;
                if (32'(cnt_reg) < MAX_NODES) begin
                    lb_we = 1'b1; lb_waddr = cnt_reg[NW-1:0]; lb_wdata = LW'(n_reg);
                    rc_we = 1'b1; rc_waddr = cnt_reg[NW-1:0]; rc_wdata = 1'b0;
                end
            end
            ST_SEED: begin
                lb_we = 1'b1; lb_waddr = t_idx_reg; lb_wdata = '0;
                rc_we = 1'b1; rc_waddr = t_idx_reg;
                gp_we = 1'b1; gp_waddr = '0; gp_wdata = CW'(1);
                qu_we = 1'b1; qu_waddr = '0; qu_wdata = t_idx_reg;
            end
            ST_BPOP: begin
                qu_re = (front_reg < rear_reg);
            end
            ST_BP: begin
                fa_re = 1'b1; fa_raddr = qu_rdata;
                lb_re = 1'b1; lb_raddr = qu_rdata;
            end
            ST_BARC: begin
                hd_re = (cur_a_reg != '0); ln_re = (cur_a_reg != '0);
            end
            ST_BH: begin
                rc_re = 1'b1;
            end
            ST_BR: begin
                if (!rc_rdata && 32'(rear_reg) < MAX_NODES) begin
                    rc_we = 1'b1; lb_we = 1'b1; qu_we = 1'b1;
                    gp_re = 1'b1; gp_raddr = gap_slot(dp_reg + LW'(1));
                end
            end
            ST_BG: begin
                gp_we = 1'b1;
            end
            ST_COPY: begin
                fa_re = (32'(cnt_reg) < MAX_NODES); fa_raddr = cnt_reg[NW-1:0];
                ca_we = (cnt_reg != '0); ca_waddr = cnt_m1[NW-1:0]; ca_wdata = fa_rdata;
            end
            ST_PNODE: begin
                if (top_node_reg != t_idx_reg) begin
                    ca_re = 1'b1; lb_re = 1'b1; lb_raddr = top_node_reg;
                end
            end
            ST_PSCAN: begin
                if (cur_a_reg != '0) begin
                    hd_re = 1'b1; ln_re = 1'b1; rs_re = 1'b1;
                end else if (ls_reg <= LW'(n_reg)) begin
                    gp_re = 1'b1; gp_raddr = gap_slot(dp_reg);
                end
            end
            ST_PH: begin
                lb_re = 1'b1; lb_raddr = hd_rdata;
            end
            ST_PL: begin
                if (admissible) begin
                    st_we = 1'b1;
                end else begin
                    ca_we = 1'b1;
                end
            end
            ST_R1: begin
                gp_we = 1'b1; gp_wdata = gap_dec;
                if (gap_zero && p_reg != s_idx_reg) begin
                    lb_we = 1'b1; lb_waddr = s_idx_reg; lb_wdata = LW'(n_reg);
                end
            end
            ST_R2: begin
                lb_we = 1'b1; lb_waddr = p_reg; lb_wdata = new_lab;
                gp_re = 1'b1; gp_raddr = gap_slot(new_lab);
            end
            ST_R3: begin
                gp_we = 1'b1;
            end
            ST_POP: begin
                st_re = (sp_reg != SPW'(1));
            end
            ST_U0: begin
                ca_re = 1'b1; ca_raddr = fr_node;
            end
            ST_U1: begin
                rs_re = 1'b1; rs_raddr = ca_rdata;
            end
            ST_U2: begin
                rs_we = 1'b1; rs_waddr = cur_a_reg; rs_wdata = rs_rdata - RW'(ret_reg);
                rs_re = 1'b1; rs_raddr = cur_a_reg ^ AW'(1);
            end
            ST_U3: begin
                rs_we = 1'b1; rs_waddr = cur_a_reg ^ AW'(1);
                rs_wdata = rs_rdata + RW'(ret_reg);
                ln_re = (got_sum != top_limit_reg);
            end
            ST_U4: begin
                ca_we = 1'b1; ca_waddr = top_node_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            src_reg       <= SOURCE_RST;
            snk_reg       <= SINK_RST;
            ncount_reg    <= NCOUNT_RST;
            arc_total_reg <= AW'(1);
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_SOURCE: src_reg    <= pwdata[PORT_NODE_W-1:0];
                    REG_SINK:   snk_reg    <= pwdata[PORT_NODE_W-1:0];
                    REG_NCOUNT: ncount_reg <= pwdata[PORT_CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + KW'(1);
                    if (32'(cnt_reg) == MAX_NODES - 1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        tail_reg <= in_tail;
                        head_reg <= in_head;
                        cap_reg  <= cap_sat;
                        a_reg    <= arc_total_reg + AW'(1);
                        s_idx_reg <= NW'(src_reg);
                        t_idx_reg <= NW'(snk_reg);
                        n_reg <= (32'(ncount_reg) > MAX_NODES) ? CW'(MAX_NODES) : CW'(ncount_reg);
                        sum_reg <= '0;
                        cnt_reg <= '0;
                        if (s_data.action == ACT_COMPUTE) begin
                            state_reg <= run_ok ? ST_INIT : ST_DONE;
                        end else if (!in_ok) begin
                            state_reg <= ST_IDLE;
                        end else if (32'(arc_total_reg) + 2 > MAX_ARCS - 1) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_ADD1;
                        end
                    end
                end
                ST_ADD1: state_reg <= ST_ADD2;
                ST_ADD2: state_reg <= ST_ADD3;
                ST_ADD3: begin
                    arc_total_reg <= a_reg + AW'(1);
                    state_reg     <= ST_IDLE;
                end
                ST_INIT: begin
                    cnt_reg <= cnt_reg + KW'(1);
                    if (32'(cnt_reg) == GS - 1) begin
                        state_reg <= ST_SEED;
                    end
                end
                ST_SEED: begin
                    front_reg <= '0;
                    rear_reg  <= CW'(1);
                    state_reg <= ST_BPOP;
                end
                ST_BPOP: begin
                    if (front_reg < rear_reg) begin
                        front_reg <= front_reg + CW'(1);
                        state_reg <= ST_BP;
                    end else begin
                        state_reg <= ST_PCHK;
                    end
                end
                ST_BP: state_reg <= ST_BA0;
                ST_BA0: begin
                    cur_a_reg <= fa_rdata;
                    dp_reg    <= lb_rdata;
                    state_reg <= ST_BARC;
                end
                ST_BARC: begin
                    state_reg <= (cur_a_reg == '0) ? ST_BPOP : ST_BH;
                end
                ST_BH: begin
                    h_reg     <= hd_rdata;
                    cur_a_reg <= ln_rdata;
                    state_reg <= ST_BR;
                end
                ST_BR: begin
                    if (!rc_rdata && 32'(rear_reg) < MAX_NODES) begin
                        rear_reg  <= rear_reg + CW'(1);
                        slot_reg  <= gap_slot(dp_reg + LW'(1));
                        state_reg <= ST_BG;
                    end else begin
                        state_reg <= ST_BARC;
                    end
                end
                ST_BG: state_reg <= ST_BARC;
                ST_PCHK: begin
                    cnt_reg   <= '0;
                    state_reg <= (ls_reg < LW'(n_reg)) ? ST_COPY : ST_DONE;
                end
                ST_COPY: begin
                    cnt_reg <= cnt_reg + KW'(1);
                    if (32'(cnt_reg) == MAX_NODES) begin
                        state_reg <= ST_PSTART;
                    end
                end
                ST_PSTART: begin
                    top_node_reg  <= s_idx_reg;
                    top_limit_reg <= PASS_LIMIT;
                    top_got_reg   <= '0;
                    sp_reg        <= SPW'(1);
                    state_reg     <= ST_PNODE;
                end
                ST_PNODE: begin
                    p_reg <= top_node_reg;
                    if (top_node_reg == t_idx_reg) begin
                        ret_reg   <= top_limit_reg;
                        state_reg <= ST_POP;
                    end else begin
                        state_reg <= ST_PCA;
                    end
                end
                ST_PCA: begin
                    cur_a_reg <= ca_rdata;
                    dp_reg    <= lb_rdata;
                    state_reg <= ST_PSCAN;
                end
                ST_PSCAN: begin
                    if (cur_a_reg != '0) begin
                        state_reg <= ST_PH;
                    end else if (ls_reg <= LW'(n_reg)) begin
                        slot_reg  <= gap_slot(dp_reg);
                        state_reg <= ST_R1;
                    end else begin
                        ret_reg   <= top_got_reg;
                        state_reg <= ST_POP;
                    end
                end
                ST_PH: state_reg <= ST_PL;
                ST_PL: begin
                    if (admissible) begin
                        top_node_reg  <= hd_rdata;
                        top_limit_reg <= child_limit;
                        top_got_reg   <= '0;
                        sp_reg        <= sp_reg + SPW'(1);
                        state_reg     <= ST_PNODE;
                    end else begin
                        cur_a_reg <= ln_rdata;
                        state_reg <= ST_PSCAN;
                    end
                end
                ST_R1: begin
                    gz_reg    <= gap_zero;
                    state_reg <= ST_R2;
                end
                ST_R2: begin
                    slot_reg  <= gap_slot(new_lab);
                    state_reg <= ST_R3;
                end
                ST_R3: begin
                    ret_reg   <= top_got_reg;
                    state_reg <= ST_POP;
                end
                ST_POP: begin
                    if (sp_reg == SPW'(1)) begin
                        sum_reg   <= sum_reg + OUT_FLOW_W'(ret_reg);
                        state_reg <= ST_PCHK;
                    end else begin
                        sp_reg    <= sp_m1;
                        state_reg <= ST_U0;
                    end
                end
                ST_U0: begin
                    top_node_reg  <= fr_node;
                    top_limit_reg <= fr_limit;
                    top_got_reg   <= fr_got;
                    state_reg     <= ST_U1;
                end
                ST_U1: begin
                    cur_a_reg <= ca_rdata;
                    state_reg <= ST_U2;
                end
                ST_U2: state_reg <= ST_U3;
                ST_U3: begin
                    if (got_sum == top_limit_reg) begin
                        ret_reg   <= got_sum;
                        state_reg <= ST_POP;
                    end else begin
                        top_got_reg <= got_sum;
                        state_reg   <= ST_U4;
                    end
                end
                ST_U4: state_reg <= ST_PNODE;
                ST_DONE: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg.flow_total     <= sum_reg;
                        m_data_reg.table_overflow <= ovf_reg;
                        ovf_reg       <= 1'b0;
                        arc_total_reg <= AW'(1);
                        cnt_reg       <= '0;
                        state_reg     <= ST_CLEAR;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (lb_we && lb_waddr == s_idx_reg) begin
                ls_reg <= lb_wdata;
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SOURCE: prdata = PDATA_W'(src_reg);
            REG_SINK:   prdata = PDATA_W'(snk_reg);
            REG_NCOUNT: prdata = PDATA_W'(ncount_reg);
            default:    prdata = '0;
        endcase
    end

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    mfisap_ram #(.WIDTH(NW), .DEPTH(MAX_ARCS)) u_arc_head (
        .aclk(aclk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .re(hd_re), .raddr(hd_raddr), .rdata(hd_rdata));
    mfisap_ram #(.WIDTH(AW), .DEPTH(MAX_ARCS)) u_arc_link (
        .aclk(aclk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
        .re(ln_re), .raddr(ln_raddr), .rdata(ln_rdata));
    mfisap_ram #(.WIDTH(RW), .DEPTH(MAX_ARCS)) u_arc_res (
        .aclk(aclk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .re(rs_re), .raddr(rs_raddr), .rdata(rs_rdata));
    mfisap_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_first_arc (
        .aclk(aclk), .we(fa_we), .waddr(fa_waddr), .wdata(fa_wdata),
        .re(fa_re), .raddr(fa_raddr), .rdata(fa_rdata));
    mfisap_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_cur_arc (
        .aclk(aclk), .we(ca_we), .waddr(ca_waddr), .wdata(ca_wdata),
        .re(ca_re), .raddr(ca_raddr), .rdata(ca_rdata));
    mfisap_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_label (
        .aclk(aclk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
        .re(lb_re), .raddr(lb_raddr), .rdata(lb_rdata));
    mfisap_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_reached (
        .aclk(aclk), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
        .re(rc_re), .raddr(rc_raddr), .rdata(rc_rdata));
    mfisap_ram #(.WIDTH(CW), .DEPTH(GS)) u_gap (
        .aclk(aclk), .we(gp_we), .waddr(gp_waddr), .wdata(gp_wdata),
        .re(gp_re), .raddr(gp_raddr), .rdata(gp_rdata));
    mfisap_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .aclk(aclk), .we(qu_we), .waddr(qu_waddr), .wdata(qu_wdata),
        .re(qu_re), .raddr(qu_raddr), .rdata(qu_rdata));
    mfisap_ram #(.WIDTH(FRW), .DEPTH(SD)) u_stack (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .re(st_re), .raddr(st_raddr), .rdata(st_rdata));

endmodule

// ===== hdl/mfisap_chk.sv =====
// port-level checker for the max flow core, bound to the top level
// depends on mfisap_pkg and max_flow_isap_gap_core_macros.svh
`include "max_flow_isap_gap_core_macros.svh"

module mfisap_chk (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input mfisap_pkg::in_word_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input mfisap_pkg::out_word_t m_data
);

    import mfisap_pkg::*;

    `MFISAP_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result word dropped or changed while stalled")
    `MFISAP_ASSERT(a_add_quiet, aclk, aresetn, s_valid && s_ready && s_data.action == ACT_ADD |=> !$rose(m_valid), "add word produced a result")
    `MFISAP_ASSERT(a_one_word, aclk, aresetn, s_valid && s_ready && s_data.action == ACT_COMPUTE |=> !s_ready, "second word taken while busy")
    `MFISAP_ASSERT_NR(a_reset_busy, aclk, !aresetn |=> !s_ready && !m_valid, "not in clearing pass after reset")

endmodule

bind max_flow_isap_gap_core mfisap_chk u_mfisap_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));

// ===== bench/tb_max_flow_isap_gap_core.sv =====
// testbench for the max flow core: loads random small graphs, runs computes, checks flow totals
// predicts each result with its own isap max flow with gap heuristic; depends on mfisap_pkg
// and max_flow_isap_gap_core
module tb_max_flow_isap_gap_core;
    import mfisap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES     = DEF_MAX_NODES;
    localparam int ARCS      = DEF_MAX_ARCS;
    localparam int GAP_SLOTS = NODES + 2;
    localparam int STK_DEPTH = NODES + 1;
    localparam longint unsigned AUG_LIMIT = 64'd1 << 30;
    localparam int SETTLE_CYCLES = 2600;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_word_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_word_t           m_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    max_flow_isap_gap_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    int unsigned        cfg_src = 0;
    int unsigned        cfg_snk = 1;
    int unsigned        cfg_cnt = 1024;
    int unsigned        arc_hd [ARCS];
    int unsigned        arc_nx [ARCS];
    longint unsigned    arc_res [ARCS];
    int unsigned        first_arc [NODES];
    int unsigned        cur_arc [NODES];
    int unsigned        lab [NODES];
    int unsigned        gap_cnt [GAP_SLOTS];
    int unsigned        bfs_q [NODES];
    bit                 seen [NODES];
    int unsigned        stk_node [STK_DEPTH];
    longint unsigned    stk_lim [STK_DEPTH];
    longint unsigned    stk_got [STK_DEPTH];
    int unsigned        arc_cnt = 1;
    bit                 ovf_seen = 1'b0;
    longint unsigned    walk_steps;

    in_word_t           item_q [$];
    out_word_t          flow_q [$];
    longint unsigned    budget = 0;
    longint unsigned    cyc = 0;
    int                 fails = 0;
    int                 mism = 0;
    int                 n_results = 0;
    int                 n_adds = 0;
    int                 n_computes = 0;
    int                 n_ovf = 0;

    function automatic int unsigned gap_slot(int unsigned l);
        return (l >= GAP_SLOTS) ? GAP_SLOTS - 1 : l;
    endfunction

    function automatic void load_arc(in_word_t w);
        int unsigned tl, hd, a;
        tl = w.edge_tail;
        hd = w.edge_head;
        if (arc_cnt + 2 > ARCS - 1) begin
            ovf_seen = 1'b1;
            return;
        end
        a = arc_cnt + 1;
        arc_hd[a] = hd;
        arc_nx[a] = first_arc[tl];
        arc_res[a] = w.edge_capacity;
        first_arc[tl] = a;
        a++;
        arc_hd[a] = tl;
        arc_nx[a] = first_arc[hd];
        arc_res[a] = 0;
        first_arc[hd] = a;
        arc_cnt = a;
    endfunction

    function automatic void label_from_sink(int unsigned t, int unsigned n);
        int unsigned front, rear, p, a, h;
        front = 0;
        rear = 0;
        for (int i = 0; i < NODES; i++) begin
            lab[i] = n;
            seen[i] = 1'b0;
        end
        for (int i = 0; i < GAP_SLOTS; i++) gap_cnt[i] = 0;
        lab[t] = 0;
        seen[t] = 1'b1;
        gap_cnt[0] = 1;
        bfs_q[rear++] = t;
        while (front < rear && front < NODES) begin
            p = bfs_q[front++];
            a = first_arc[p];
            while (a != 0) begin
                walk_steps++;
                h = arc_hd[a];
                if (!seen[h] && rear < NODES) begin
                    seen[h] = 1'b1;
                    lab[h] = lab[p] + 1;
                    gap_cnt[gap_slot(lab[h])]++;
                    bfs_q[rear++] = h;
                end
                a = arc_nx[a];
            end
        end
    endfunction

    function automatic longint unsigned augment_pass(int unsigned s, int unsigned t,
                                                     int unsigned n);
        int unsigned sp, p, a, h, g, q;
        longint unsigned ret, room;
        bit pushed;
        stk_node[0] = s;
        stk_lim[0] = AUG_LIMIT;
        stk_got[0] = 0;
        sp = 1;
        forever begin
            p = stk_node[sp-1];
            pushed = 1'b0;
            if (p == t) begin
                ret = stk_lim[sp-1];
            end else begin
                a = cur_arc[p];
                while (a != 0) begin
                    walk_steps++;
                    h = arc_hd[a];
                    if (lab[p] == lab[h] + 1 && arc_res[a] != 0 && sp < STK_DEPTH) begin
                        room = stk_lim[sp-1] - stk_got[sp-1];
                        stk_node[sp] = h;
                        stk_lim[sp] = (room < arc_res[a]) ? room : arc_res[a];
                        stk_got[sp] = 0;
                        sp++;
                        pushed = 1'b1;
                        break;
                    end
                    a = arc_nx[a];
                    cur_arc[p] = a;
                end
                if (!pushed) begin
                    if (lab[s] <= n) begin
                        g = gap_slot(lab[p]);
                        if (gap_cnt[g] > 0) gap_cnt[g]--;
                        if (gap_cnt[g] == 0) lab[s] = n;
                        lab[p]++;
                        gap_cnt[gap_slot(lab[p])]++;
                    end
                    ret = stk_got[sp-1];
                end
            end
            if (pushed) continue;
            sp--;
            forever begin
                if (sp == 0) return ret;
                q = stk_node[sp-1];
                a = cur_arc[q];
                arc_res[a] -= ret;
                arc_res[a ^ 1] += ret;
                stk_got[sp-1] += ret;
                if (stk_got[sp-1] == stk_lim[sp-1]) begin
                    ret = stk_got[sp-1];
                    sp--;
                end else begin
                    cur_arc[q] = arc_nx[a];
                    break;
                end
            end
        end
    endfunction

    function automatic out_word_t predict_flow();
        out_word_t r;
        int unsigned n, passes;
        longint unsigned total;
        n = (cfg_cnt > NODES) ? NODES : cfg_cnt;
        total = 0;
        passes = 0;
        walk_steps = 0;
        if (cfg_src != cfg_snk) begin
            label_from_sink(cfg_snk, n);
            while (lab[cfg_src] < n) begin
                for (int i = 0; i < NODES; i++) cur_arc[i] = first_arc[i];
                total += augment_pass(cfg_src, cfg_snk, n);
                passes++;
            end
        end
        r.flow_total = total[OUT_FLOW_W-1:0];
        r.table_overflow = ovf_seen;
        for (int i = 0; i < NODES; i++) first_arc[i] = 0;
        arc_cnt = 1;
        ovf_seen = 1'b0;
        budget += 4 * (4 * NODES + 64 + longint'(passes) * (NODES + 64) + 8 * walk_steps)
                  + 4000;
        return r;
    endfunction

    // sender: bursts and gaps
    logic s_fire = 1'b0;
    int   burst_left = 8;
    int   gap_left = 0;

    always @(posedge aclk) begin
        s_fire <= s_valid && s_ready;
    end

    always @(negedge aclk) begin
        in_word_t w;
        logic     nv;
        if (aresetn) begin
            nv = s_valid;
            if (!s_valid || s_fire) begin
                nv = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (item_q.size() > 0) begin
                    w = item_q.pop_front();
                    if (w.action == ACT_ADD) begin
                        load_arc(w);
                        budget += 80;
                    end else begin
                        flow_q.push_back(predict_flow());
                    end
                    s_data <= w;
                    nv = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            s_valid <= nv;
        end
    end

    // receiver: stall pattern switches at random among three modes
    int stall_mode = 0;
    int stall_left = 100;

    always @(negedge aclk) begin
        logic rdy;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(50, 300);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            default: rdy = ($urandom_range(0, 7) == 0);
        endcase
        m_ready <= rdy;
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        out_word_t want;
        cyc++;
        if (cyc > budget + 200000) begin
            $display("timeout after %0d cycles, %0d words still expected", cyc, flow_q.size());
            $display("tb_max_flow_isap_gap_core: FAIL");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (flow_q.size() == 0) begin
                fails++;
                mism++;
                if (mism <= 10)
                    $display("unexpected result word flow %0d ovf %0d",
                             m_data.flow_total, m_data.table_overflow);
            end else begin
                want = flow_q.pop_front();
                if (m_data.table_overflow) n_ovf++;
                if (m_data.flow_total !== want.flow_total ||
                    m_data.table_overflow !== want.table_overflow) begin
                    fails++;
                    mism++;
                    if (mism <= 10)
                        $display("result %0d mismatch: flow exp %0d got %0d, ovf exp %0d got %0d",
                                 n_results, want.flow_total, m_data.flow_total,
                                 want.table_overflow, m_data.table_overflow);
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SOURCE: cfg_src = val & 32'h3ff;
            REG_SINK:   cfg_snk = val & 32'h3ff;
            default:    cfg_cnt = val & 32'h7ff;
        endcase
    endtask

    task automatic set_config(input int unsigned s, input int unsigned t, input int unsigned n);
        write_reg(REG_SOURCE, s);
        write_reg(REG_SINK, t);
        write_reg(REG_NCOUNT, n);
    endtask

    task automatic add_arc(input int unsigned tl, input int unsigned hd, input int unsigned c);
        in_word_t w;
        w.action = ACT_ADD;
        w.edge_tail = PORT_NODE_W'(tl);
        w.edge_head = PORT_NODE_W'(hd);
        w.edge_capacity = PORT_CAP_W'(c);
        item_q.push_back(w);
        n_adds++;
    endtask

    task automatic ask_flow();
        in_word_t w;
        w.action = ACT_COMPUTE;
        w.edge_tail = PORT_NODE_W'($urandom);
        w.edge_head = PORT_NODE_W'($urandom);
        w.edge_capacity = PORT_CAP_W'($urandom);
        item_q.push_back(w);
        n_computes++;
    endtask

    task automatic settle();
        while (item_q.size() > 0 || s_valid || flow_q.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic int unsigned pick_cap();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 32'h4000_0000;
            2: return 32'h7fff_ffff;
            3: return $urandom & 32'h7fff_ffff;
            default: return $urandom_range(1, 100);
        endcase
    endfunction

    initial begin
        int unsigned pool [8];
        int unsigned s, t, n, k, m, tl, hd;
        int phases;
        phases = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (1500) @(negedge aclk);

        // default config: empty graph, parallel arcs, two-hop path, self loop
        ask_flow();
        add_arc(0, 1, 32'h4000_0000);
        add_arc(0, 1, 32'h7fff_ffff);
        add_arc(0, 2, 5);
        add_arc(2, 1, 3);
        add_arc(1023, 1023, 7);
        add_arc(2, 0, 0);
        ask_flow();
        // no path with capacity from source to sink
        add_arc(1, 0, 9);
        add_arc(3, 1, 0);
        ask_flow();
        settle();

        // source equals sink
        set_config(5, 5, 1024);
        add_arc(5, 6, 10);
        add_arc(6, 5, 10);
        ask_flow();
        settle();

        // node count too small for the path
        set_config(3, 4, 2);
        add_arc(3, 7, 11);
        add_arc(7, 8, 12);
        add_arc(8, 4, 13);
        add_arc(3, 4, 2);
        ask_flow();
        settle();

        // extremes of the node range
        set_config(1023, 0, 2047);
        add_arc(1023, 512, 32'h7fff_ffff);
        add_arc(512, 0, 32'h7fff_ffff);
        add_arc(1023, 0, 1);
        ask_flow();
        settle();
        phases = 4;

        while (n_adds + n_computes < 1530) begin
            s = $urandom_range(0, 1023);
            t = ($urandom_range(0, 7) == 0) ? s : $urandom_range(0, 1023);
            case ($urandom_range(0, 5))
                0: n = 2;
                1: n = 1024;
                2: n = $urandom_range(1025, 2047);
                3: n = $urandom_range(0, 8);
                default: n = $urandom_range(2, 1024);
            endcase
            set_config(s, t, n);
            repeat ($urandom_range(2, 5)) begin
                k = $urandom_range(2, 7);
                pool[0] = s;
                pool[1] = t;
                for (int i = 2; i < 8; i++) pool[i] = $urandom_range(0, 1023);
                m = $urandom_range(0, 20);
                for (int i = 0; i < m; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        tl = $urandom_range(0, 1023);
                        hd = $urandom_range(0, 1023);
                    end else begin
                        tl = pool[$urandom_range(0, k - 1)];
                        hd = pool[$urandom_range(0, k - 1)];
                    end
                    add_arc(tl, hd, pick_cap());
                end
                ask_flow();
            end
            settle();
            phases++;
        end

        $display("ran %0d phases: %0d arc words, %0d computes, %0d results",
                 phases, n_adds, n_computes, n_results);
        $display("%0d results flagged table overflow, %0d mismatches", n_ovf, mism);
        if (fails == 0 && flow_q.size() == 0) begin
            $display("tb_max_flow_isap_gap_core: PASS");
        end else begin
            $display("tb_max_flow_isap_gap_core: FAIL");
        end
        $finish;
    end

endmodule
